### hdl/hdlc_async_frame_encoder_unit_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef HDLC_ASYNC_FRAME_ENCODER_UNIT_DEFINES_SVH
`define HDLC_ASYNC_FRAME_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HAFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define HAFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/hafe_pkg.sv
`default_nettype none
package hafe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // Fixed slot order of the line bytes one payload byte can cause.
  localparam logic [2:0] SLOT_OPEN    = 3'd0;
  localparam logic [2:0] SLOT_ESC_DAT = 3'd1;
  localparam logic [2:0] SLOT_DATA    = 3'd2;
  localparam logic [2:0] SLOT_ESC_LO  = 3'd3;
  localparam logic [2:0] SLOT_FCS_LO  = 3'd4;
  localparam logic [2:0] SLOT_ESC_HI  = 3'd5;
  localparam logic [2:0] SLOT_FCS_HI  = 3'd6;
  localparam logic [2:0] SLOT_CLOSE   = 3'd7;

  typedef struct packed {
    logic [7:0] slot_mask;
    logic [7:0] data_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
  } burst_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] v;
    v = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ FCS_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] stuffed(input logic [7:0] b);
    return needs_escape(b) ? (b ^ ESC_XOR) : b;
  endfunction

endpackage
`default_nettype wire

### hdl/hafe_if.sv
`default_nettype none
interface hafe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, output data_byte, output frame_end, input ready);
  modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

interface hafe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       closing_flag;

  modport source(output valid, output out_byte, output run_last, output closing_flag,
                 input ready);
  modport sink(input valid, input out_byte, input run_last, input closing_flag,
               output ready);
endinterface
`default_nettype wire

### hdl/hafe_front.sv
`default_nettype none
`include "hdlc_async_frame_encoder_unit_defines.svh"
module hafe_front
  import hafe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  hafe_in_if.sink     in_ch,
  output burst_t      burst,
  output logic        burst_valid,
  input  wire logic   burst_ready
);

  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_end;
  logic        inside_frame;
  logic [15:0] running_fcs;
  logic [15:0] fcs_next;
  logic [15:0] fcs_final;
  logic        move;

  assign in_ch.ready = !in_valid || burst_ready;
  assign move        = in_valid && burst_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data <= in_ch.data_byte;
      in_end  <= in_ch.frame_end;
    end
  end

  // running_fcs is back at its initial value whenever no frame is open
  assign fcs_next  = fcs_update(running_fcs, in_data);
  assign fcs_final = fcs_next ^ FCS_INIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      running_fcs  <= FCS_INIT;
    end else if (move) begin
      if (in_end) begin
        inside_frame <= 1'b0;
        running_fcs  <= FCS_INIT;
      end else begin
        inside_frame <= 1'b1;
        running_fcs  <= fcs_next;
      end
    end
  end

  always_comb begin
    burst.slot_mask               = '0;
    burst.slot_mask[SLOT_OPEN]    = !inside_frame;
    burst.slot_mask[SLOT_ESC_DAT] = needs_escape(in_data);
    burst.slot_mask[SLOT_DATA]    = 1'b1;
    burst.slot_mask[SLOT_ESC_LO]  = in_end && needs_escape(fcs_final[7:0]);
    burst.slot_mask[SLOT_FCS_LO]  = in_end;
    burst.slot_mask[SLOT_ESC_HI]  = in_end && needs_escape(fcs_final[15:8]);
    burst.slot_mask[SLOT_FCS_HI]  = in_end;
    burst.slot_mask[SLOT_CLOSE]   = in_end;
    burst.data_byte               = stuffed(in_data);
    burst.lo_byte                 = stuffed(fcs_final[7:0]);
    burst.hi_byte                 = stuffed(fcs_final[15:8]);
  end

  assign burst_valid = in_valid;

  `HAFE_ASSERT_NEXT(a_close_resets, clk, rst, move && in_end, !inside_frame && running_fcs == FCS_INIT, "frame close did not restore state")
  `HAFE_ASSERT_NOW(a_idle_fcs, clk, rst, !inside_frame, running_fcs == FCS_INIT, "fcs not initial outside a frame")
  `HAFE_ASSERT_NEXT(a_hold_stage, clk, rst, in_valid && !burst_ready, in_valid && $stable(in_data) && $stable(in_end), "input stage lost item under stall")

endmodule
`default_nettype wire

### hdl/hafe_ser.sv
`default_nettype none
`include "hdlc_async_frame_encoder_unit_defines.svh"
module hafe_ser
  import hafe_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire burst_t burst,
  input  wire logic   burst_valid,
  output logic        burst_ready,
  hafe_out_if.source  out_ch
);

  logic [7:0] mask;
  logic [7:0] rest;
  logic [7:0] data_byte;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  logic [2:0] cur;
  logic       busy;
  logic       xfer;

  assign busy = |mask;
  assign rest = mask & (mask - 8'd1);
  assign xfer = out_ch.valid && out_ch.ready;

  always_comb begin
    cur = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) begin
        cur = 3'(i);
      end
    end
  end

  assign burst_ready = !busy || (xfer && rest == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (burst_valid && burst_ready) begin
      mask <= burst.slot_mask;
    end else if (xfer) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      data_byte <= burst.data_byte;
      lo_byte   <= burst.lo_byte;
      hi_byte   <= burst.hi_byte;
    end
  end

  always_comb begin
    case (cur)
      SLOT_OPEN:    out_ch.out_byte = FLAG_BYTE;
      SLOT_ESC_DAT: out_ch.out_byte = ESC_BYTE;
      SLOT_DATA:    out_ch.out_byte = data_byte;
      SLOT_ESC_LO:  out_ch.out_byte = ESC_BYTE;
      SLOT_FCS_LO:  out_ch.out_byte = lo_byte;
      SLOT_ESC_HI:  out_ch.out_byte = ESC_BYTE;
      SLOT_FCS_HI:  out_ch.out_byte = hi_byte;
      SLOT_CLOSE:   out_ch.out_byte = FLAG_BYTE;
      default:      out_ch.out_byte = FLAG_BYTE;
    endcase
  end

  assign out_ch.valid        = busy;
  assign out_ch.run_last     = (rest == 8'd0);
  assign out_ch.closing_flag = (cur == SLOT_CLOSE);

  `HAFE_ASSERT_NOW(a_close_is_last, clk, rst, out_ch.valid && out_ch.closing_flag, out_ch.run_last, "closing flag not last of run")
  `HAFE_ASSERT_NEXT(a_stall_holds, clk, rst, busy && !out_ch.ready, mask == $past(mask), "pending bytes changed under stall")
  `HAFE_ASSERT_NEXT(a_run_continues, clk, rst, xfer && !out_ch.run_last, busy, "run ended early")

endmodule
`default_nettype wire

### hdl/hdlc_async_frame_encoder_unit.sv
// HDLC-style async framer: takes one payload byte per transfer on in_ch, with frame_end
// on the frame's last byte, and sends line bytes on out_ch one per transfer. A byte that
// opens a frame is preceded by the 0x7E flag; 0x7E and 0x7D are escaped as 0x7D, byte^0x20;
// the last byte is followed by the complemented FCS-16 (0x8408 reflected, init 0xFFFF),
// low byte first and escaped the same way, then the closing 0x7E flag, which also carries
// closing_flag. run_last marks the final line byte caused by each input byte. An input byte
// produces 1 to 8 line bytes and holds the single output byte port until all are sent;
// with one line byte per input and out_ch not stalled, it takes a new byte every cycle.
// An item's first line byte goes through the input register, then the burst register.
`default_nettype none
module hdlc_async_frame_encoder_unit
  import hafe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  hafe_in_if.sink    in_ch,
  hafe_out_if.source out_ch
);

  // Burst of slot-coded line bytes from the front stage to the serializer.
  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  // Front: input register, FCS and frame state, escape decisions.
  hafe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready)
  );

  // Serializer: hold the burst, advance through its set slots one transfer at a time.
  hafe_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
